// File: rtl/uart_8n1_transceiver_unit_assert.svh
// Assertion macros used by the checker file of the serial transceiver.
`ifndef UART_8N1_TRANSCEIVER_UNIT_ASSERT_SVH
`define UART_8N1_TRANSCEIVER_UNIT_ASSERT_SVH

// Same-cycle implication, switched off while reset is asserted.
`define UART_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("uart check failed");

// Next-cycle implication, switched off while reset is asserted.
`define UART_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("uart check failed");

`endif

// File: rtl/uart8n1_pkg.sv
package uart8n1_pkg;

  // Data bits per frame by default.
  localparam int unsigned DataBitsDefault = 8;

  // Bit period register.
  localparam int unsigned BitPeriodW = 16;
  localparam logic [BitPeriodW-1:0] BitPeriodReset = 16'd104;

  // The receiver's first wait is one and a half bit periods, so one bit wider.
  localparam int unsigned RxTimerW = BitPeriodW + 1;

  // One word in: one clock tick of line time.
  typedef struct packed {
    logic       rx_line;
    logic       tx_start;
    logic [7:0] tx_byte;
    logic       tx_target;
  } in_t;

  // One word out: line levels and status after that tick.
  typedef struct packed {
    logic       tx_line_card;
    logic       tx_line_host;
    logic       tx_busy;
    logic       tx_refused;
    logic       rx_valid;
    logic [7:0] rx_byte;
  } out_t;

endpackage

// File: rtl/uart8n1_if.sv
// Input channel: one tick of line samples and transmit requests.
interface uart8n1_in_if;
  logic              valid;
  logic              ready;
  uart8n1_pkg::in_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// Output channel: line levels and status for each tick.
interface uart8n1_out_if;
  logic              valid;
  logic              ready;
  uart8n1_pkg::out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/uart_8n1_transceiver_unit.sv
// Channel   Direction  Word                                   Handshake
// in_i      sink       rx_line, tx_start, tx_byte, tx_target  valid / ready
// out_o     source     tx_line_card/host, tx_busy, tx_refused, valid / ready
//                      rx_valid, rx_byte
// cfg       write      cfg_data_i (bit period)                cfg_we_i
//
// One word is taken every cycle while in_i.ready is high; its result word appears
// in the next cycle, from the single output register after the state update.
// Reset (rst_ni low, asynchronous) sets the receiver hunting, the transmitter
// idle with both lines high, and the bit period to 104 ticks.
// When the output register is full and not taken, in_i.ready drops and
// the line state holds until the result is taken.
module uart_8n1_transceiver_unit #(
  parameter int unsigned DATA_BITS = uart8n1_pkg::DataBitsDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [uart8n1_pkg::BitPeriodW-1:0]  cfg_data_i,
  uart8n1_in_if.sink                          in_i,
  uart8n1_out_if.source                       out_o
);

  localparam int unsigned FrameBits = DATA_BITS + 2;
  localparam int unsigned RxCntW    = $clog2(DATA_BITS + 1);
  localparam int unsigned TxCntW    = $clog2(FrameBits + 1);
  localparam int unsigned RxTimerW  = uart8n1_pkg::RxTimerW;
  localparam int unsigned BitPeriodW = uart8n1_pkg::BitPeriodW;

  typedef enum logic [1:0] {
    RX_HUNT = 2'd0,
    RX_DATA = 2'd1,
    RX_STOP = 2'd2
  } rx_phase_e;

  logic [BitPeriodW-1:0] bit_period_q;

  rx_phase_e             rx_phase_q, rx_phase_d;
  logic [RxTimerW-1:0]   rx_timer_q, rx_timer_d;
  logic [DATA_BITS-1:0]  rx_shift_q, rx_shift_d;
  logic [RxCntW-1:0]     rx_left_q, rx_left_d;

  logic [BitPeriodW-1:0] tx_timer_q, tx_timer_d;
  logic [FrameBits-1:0]  tx_shift_q, tx_shift_d;
  logic [TxCntW-1:0]     tx_left_q, tx_left_d;
  logic                  tx_sel_q, tx_sel_d;

  logic                  out_valid_q;
  uart8n1_pkg::out_t     out_q, out_d;

  logic                  in_fire;
  logic                  rx_valid;
  logic                  tx_refused;
  logic                  tx_busy;
  logic                  tx_level;

  // A word is taken whenever the output register is free or being emptied.
  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign in_fire     = in_i.valid && in_i.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // Receiver: hunt for a start bit, wait, sample data bits, wait out the stop bit.
  always_comb begin
    rx_phase_d = rx_phase_q;
    rx_timer_d = rx_timer_q;
    rx_shift_d = rx_shift_q;
    rx_left_d  = rx_left_q;
    rx_valid   = 1'b0;
    case (rx_phase_q)
      RX_DATA: begin
        if (rx_timer_q > RxTimerW'(1)) begin
          rx_timer_d = rx_timer_q - RxTimerW'(1);
        end else begin
          rx_shift_d = {in_i.data.rx_line, rx_shift_q[DATA_BITS-1:1]};
          if (rx_left_q != '0) begin
            rx_left_d = rx_left_q - RxCntW'(1);
          end
          rx_timer_d = RxTimerW'(bit_period_q);
          if (rx_left_d == '0) begin
            rx_valid   = 1'b1;
            rx_phase_d = RX_STOP;
          end
        end
      end
      RX_STOP: begin
        if (rx_timer_q > RxTimerW'(1)) begin
          rx_timer_d = rx_timer_q - RxTimerW'(1);
        end else begin
          rx_phase_d = RX_HUNT;
        end
      end
      default: begin
        // The unused phase code behaves as hunting.
        rx_phase_d = RX_HUNT;
        if (!in_i.data.rx_line) begin
          rx_phase_d = RX_DATA;
          rx_timer_d = RxTimerW'(bit_period_q) + RxTimerW'(bit_period_q[BitPeriodW-1:1]);
          rx_left_d  = RxCntW'(DATA_BITS);
        end
      end
    endcase
  end

  // Transmitter: advance the frame on the line, then take or refuse a request.
  always_comb begin
    tx_timer_d = tx_timer_q;
    tx_shift_d = tx_shift_q;
    tx_left_d  = tx_left_q;
    tx_sel_d   = tx_sel_q;
    tx_refused = 1'b0;
    if (tx_left_q != '0) begin
      if (tx_timer_q > BitPeriodW'(1)) begin
        tx_timer_d = tx_timer_q - BitPeriodW'(1);
      end else begin
        tx_shift_d = {1'b1, tx_shift_q[FrameBits-1:1]};
        tx_left_d  = tx_left_q - TxCntW'(1);
        tx_timer_d = bit_period_q;
      end
    end
    if (in_i.data.tx_start) begin
      if (tx_left_d != '0) begin
        tx_refused = 1'b1;
      end else begin
        tx_shift_d = {1'b1, DATA_BITS'(in_i.data.tx_byte), 1'b0};
        tx_left_d  = TxCntW'(FrameBits);
        tx_timer_d = bit_period_q;
        tx_sel_d   = in_i.data.tx_target;
      end
    end
  end

  // Result word for this tick.
  assign tx_busy  = (tx_left_d != '0);
  assign tx_level = tx_busy ? tx_shift_d[0] : 1'b1;

  always_comb begin
    out_d.tx_line_card = tx_sel_d ? 1'b1 : tx_level;
    out_d.tx_line_host = tx_sel_d ? tx_level : 1'b1;
    out_d.tx_busy      = tx_busy;
    out_d.tx_refused   = tx_refused;
    out_d.rx_valid     = rx_valid;
    out_d.rx_byte      = rx_valid ? 8'(rx_shift_d) : 8'd0;
  end

  // Bit period register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_period_q <= uart8n1_pkg::BitPeriodReset;
    end else if (cfg_we_i) begin
      bit_period_q <= cfg_data_i;
    end
  end

  // Line state, advanced once for every word taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_phase_q <= RX_HUNT;
      rx_timer_q <= '0;
      rx_shift_q <= '0;
      rx_left_q  <= '0;
      tx_timer_q <= '0;
      tx_shift_q <= '1;
      tx_left_q  <= '0;
      tx_sel_q   <= 1'b0;
    end else if (in_fire) begin
      rx_phase_q <= rx_phase_d;
      rx_timer_q <= rx_timer_d;
      rx_shift_q <= rx_shift_d;
      rx_left_q  <= rx_left_d;
      tx_timer_q <= tx_timer_d;
      tx_shift_q <= tx_shift_d;
      tx_left_q  <= tx_left_d;
      tx_sel_q   <= tx_sel_d;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= out_d;
    end
  end

endmodule

// File: rtl/uart8n1_checker.sv
`include "uart_8n1_transceiver_unit_assert.svh"

module uart8n1_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input uart8n1_pkg::out_t out_data_i
);

  logic out_held;
  logic refused_shown;
  logic idle_shown;
  logic lines_high;
  logic no_byte_shown;

  // Conditions on the result word as it stands on the output port.
  assign out_held      = out_valid_i && !out_ready_i;
  assign refused_shown = out_valid_i && out_data_i.tx_refused;
  assign idle_shown    = out_valid_i && !out_data_i.tx_busy;
  assign lines_high    = out_data_i.tx_line_card && out_data_i.tx_line_host;
  assign no_byte_shown = out_valid_i && !out_data_i.rx_valid;

  // A held result word keeps its contents until taken.
  `UART_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_held, out_valid_i && $stable(out_data_i))

  // The input side is open whenever no result waits.
  `UART_ASSERT_IMPL(a_ready_free, clk_i, rst_ni, !out_valid_i, in_ready_i)

  // A refused request means a frame is still going out.
  `UART_ASSERT_IMPL(a_refused_busy, clk_i, rst_ni, refused_shown, out_data_i.tx_busy)

  // An idle transmitter leaves both lines high.
  `UART_ASSERT_IMPL(a_idle_lines, clk_i, rst_ni, idle_shown, lines_high)

  // The received byte reads zero unless flagged.
  `UART_ASSERT_IMPL(a_rx_byte_zero, clk_i, rst_ni, no_byte_shown, out_data_i.rx_byte == 8'd0)

endmodule

bind uart_8n1_transceiver_unit uart8n1_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
